/* sv/bisection_square_root_top_macros.svh */
// Assertion macros for the bisection square root block.
// Used by the top level only; no other dependencies.
`ifndef BISECTION_SQUARE_ROOT_TOP_MACROS_SVH
`define BISECTION_SQUARE_ROOT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bsr_pkg.sv */
// Shared types and constants for the bisection square root block.
// No dependencies; imported by the controller, datapath and top level.
package bsr_pkg;

   localparam int ROOT_BITS     = 32;
   localparam int RADICAND_BITS = 32;
   localparam int TARGET_BITS   = 2 * ROOT_BITS;
   localparam int STEP_W        = $clog2(ROOT_BITS);
   localparam int DEF_FRAC_BITS = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_step;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

/* sv/bsr_ctrl.sv */
// Controller state machine for the bisection square root block.
// Depends on bsr_pkg for the command, status and state types.
module bsr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  bsr_pkg::sts_type sts,
   output bsr_pkg::cmd_type cmd
);
   import bsr_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.start    = 1'b0;
      cmd.step     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result waits here until the output register is free.
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* sv/bsr_dpath.sv */
// Datapath of the bisection square root block: one root bit per step.
// Depends on bsr_pkg for widths and the command and status types.
module bsr_dpath #(
   parameter int FRAC_BITS = bsr_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bsr_pkg::cmd_type                    cmd,
   output bsr_pkg::sts_type                    sts,
   input  logic [bsr_pkg::RADICAND_BITS-1:0]   req_radicand,
   output logic [bsr_pkg::ROOT_BITS-1:0]       rsp_root,
   output logic                                rsp_negative_error
);
   import bsr_pkg::*;

   localparam int REM_W = ROOT_BITS + 2;
   localparam int SH_W  = REM_W + 2;

   logic [TARGET_BITS-1:0] tgt_ff, tgt_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [ROOT_BITS-1:0]   out_root_ff, out_root_in;
   logic                   out_err_ff, out_err_in;

   logic [SH_W-1:0]        rem_sh;
   logic [SH_W-1:0]        trial;
   logic [SH_W-1:0]        diff;
   logic                   take;

   // Deciding a root bit: the candidate with this bit set squares to no
   // more than the target exactly when the partial remainder covers 4q+1.
   assign rem_sh = {rem_ff, tgt_ff[TARGET_BITS-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign take   = (rem_sh >= trial);

   assign sts.last_step = (cnt_ff == STEP_W'(ROOT_BITS - 1));

   always_comb begin
      tgt_in      = tgt_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      out_root_in = out_root_ff;
      out_err_in  = out_err_ff;
      if (cmd.start) begin
         tgt_in  = {{(TARGET_BITS-RADICAND_BITS){1'b0}}, req_radicand} << (2 * FRAC_BITS);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         neg_in  = req_radicand[RADICAND_BITS-1];
      end
      if (cmd.step) begin
         tgt_in  = {tgt_ff[TARGET_BITS-3:0], 2'b00};
         rem_in  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_BITS-2:0], take};
         cnt_in  = cnt_ff + STEP_W'(1);
      end
      if (cmd.load_out) begin
         out_root_in = neg_ff ? '0 : root_ff;
         out_err_in  = neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      neg_ff      <= neg_in;
      out_root_ff <= out_root_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_root           = out_root_ff;
   assign rsp_negative_error = out_err_ff;

endmodule

/* sv/bisection_square_root_top.sv */
// Top level of the bisection square root block.
// Depends on bsr_pkg, bsr_ctrl, bsr_dpath and the assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata: radicand (signed, 32 bits)
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: root (Q16.16), rsp_tuser: error flag
//
// Each item runs in order: the accepting edge loads the operand, the root recurrence then
// produces one root bit per cycle for all 32 root bits, and a final step loads the
// output register once it is free. A new item is accepted the cycle after the result
// loads, so the block takes no new item while one is still in progress.
// Reset is synchronous and active high; it clears the controller and step count.
// A stalled result sits in the output register while the next item is worked on;
// only when that item finishes too does the controller wait for the register.
module bisection_square_root_top #(
   parameter int FRAC_BITS = bsr_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsr_pkg::RADICAND_BITS-1:0] req_tdata,  // [31:0] radicand
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsr_pkg::ROOT_BITS-1:0]     rsp_tdata,  // [31:0] root
   output logic                              rsp_tuser   // [0] negative_error
);
   import bsr_pkg::*;

`include "bisection_square_root_top_macros.svh"

   cmd_type cmd;
   sts_type sts;

   // The controller sequences load, the bit steps and the output register.
   bsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the operand, partial remainder, root and result.
   bsr_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_radicand       (req_tdata),
      .rsp_root           (rsp_tdata),
      .rsp_negative_error (rsp_tuser)
   );

   // After an item is taken, the block is busy with it.
   `BSR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input accepted while an item is in progress")
   // A result is only loaded into a free or draining output register.
   `BSR_ASSERT_NOW(a_load_into_free_slot, clock, reset, cmd.load_out, !rsp_tvalid || rsp_tready, "result overwrote one not yet taken")
   // A flagged negative radicand always reports a zero root.
   `BSR_ASSERT_NOW(a_negative_gives_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "negative radicand with nonzero root")
   // The final bit step always hands over to the result load.
   `BSR_ASSERT_NEXT(a_last_step_finishes, clock, reset, cmd.step && sts.last_step, !cmd.step, "bit steps ran past the last root bit")

endmodule
